FILE: src/drus_pkg.sv
// Shared types and constants for the damage rectangle update selector.
// Depends on nothing; every other file in src imports it.
`default_nettype none

package drus_pkg;

    // Coordinate and derived widths.
    localparam int COORD_BITS = 16;
    localparam int EDGE_BITS  = COORD_BITS + 1;
    localparam int AREA_BITS  = 2 * COORD_BITS;
    localparam int WAVE_BITS  = 8;

    // The fast waveform is used below one sixteenth of the panel area.
    localparam int SMALL_SHIFT = 4;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = COORD_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PANEL_WIDTH     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PANEL_HEIGHT    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NORMAL_WAVEFORM = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FAST_WAVEFORM   = 2'd3;

    localparam logic [COORD_BITS-1:0] PANEL_WIDTH_RESET     = 16'd1024;
    localparam logic [COORD_BITS-1:0] PANEL_HEIGHT_RESET    = 16'd768;
    localparam logic [WAVE_BITS-1:0]  NORMAL_WAVEFORM_RESET = 8'd2;
    localparam logic [WAVE_BITS-1:0]  FAST_WAVEFORM_RESET   = 8'd1;

    // Request operation codes.
    localparam logic OP_DAMAGE    = 1'b0;
    localparam logic OP_FRAME_END = 1'b1;

    // Input request.
    typedef struct packed {
        logic                  operation;
        logic [COORD_BITS-1:0] dmg_x;
        logic [COORD_BITS-1:0] dmg_y;
        logic [COORD_BITS-1:0] dmg_w;
        logic [COORD_BITS-1:0] dmg_h;
        logic                  capture_ok;
        logic [COORD_BITS-1:0] capture_width;
        logic [COORD_BITS-1:0] capture_height;
    } in_item_t;

    // Output request.
    typedef struct packed {
        logic [COORD_BITS-1:0] upd_top;
        logic [COORD_BITS-1:0] upd_left;
        logic [COORD_BITS-1:0] upd_width;
        logic [COORD_BITS-1:0] upd_height;
        logic [WAVE_BITS-1:0]  waveform_id;
        logic                  rescaled;
    } out_item_t;

    // Region chosen by the front end, waiting for waveform selection.
    typedef struct packed {
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] width;
        logic [COORD_BITS-1:0] height;
        logic                  rescaled;
    } region_t;

    // Current configuration register values.
    typedef struct packed {
        logic [COORD_BITS-1:0] panel_width;
        logic [COORD_BITS-1:0] panel_height;
        logic [WAVE_BITS-1:0]  normal_waveform;
        logic [WAVE_BITS-1:0]  fast_waveform;
    } cfg_t;

endpackage

`default_nettype wire

FILE: src/drus_front.sv
// Front end: accepts requests, merges damage into a bounding box and picks
// the region to refresh at each frame end. Depends on drus_pkg.
`default_nettype none

module drus_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire drus_pkg::in_item_t in_data,
    input  wire drus_pkg::cfg_t     cfg,
    input  wire logic              q_full,
    output logic                   q_push,
    output drus_pkg::region_t      q_data
);
    import drus_pkg::*;

    // Length of [start, stop) after clamping it to [0, limit).
    function automatic logic [COORD_BITS-1:0] clamp_span(
        input logic [COORD_BITS-1:0] start,
        input logic [EDGE_BITS-1:0]  stop,
        input logic [COORD_BITS-1:0] limit
    );
        logic [EDGE_BITS-1:0] lim_e;
        logic [EDGE_BITS-1:0] start_e;
        logic [EDGE_BITS-1:0] stop_c;
        logic [EDGE_BITS-1:0] diff;
        lim_e   = {1'b0, limit};
        start_e = {1'b0, start};
        stop_c  = (stop > lim_e) ? lim_e : stop;
        diff    = stop_c - start_e;
        if (start_e >= lim_e || stop_c <= start_e)
        begin
            return '0;
        end
        return diff[COORD_BITS-1:0];
    endfunction

    logic [COORD_BITS-1:0] acc_left_reg, acc_left_next;
    logic [COORD_BITS-1:0] acc_top_reg, acc_top_next;
    logic [EDGE_BITS-1:0]  acc_right_reg, acc_right_next;
    logic [EDGE_BITS-1:0]  acc_bottom_reg, acc_bottom_next;
    logic                  damage_seen_reg, damage_seen_next;
    logic                  first_frame_reg, first_frame_next;

    logic                  accept;
    logic                  is_damage;
    logic                  is_frame_end;
    logic [EDGE_BITS-1:0]  dmg_right;
    logic [EDGE_BITS-1:0]  dmg_bottom;
    logic                  use_damage;
    logic                  size_match;
    logic [COORD_BITS-1:0] sel_left;
    logic [COORD_BITS-1:0] sel_top;
    logic [EDGE_BITS-1:0]  sel_right;
    logic [EDGE_BITS-1:0]  sel_bottom;
    logic [COORD_BITS-1:0] span_w;
    logic [COORD_BITS-1:0] span_h;

    // A request is taken whenever the queue has room.
    assign in_ready     = !q_full;
    assign accept       = in_valid && in_ready;
    assign is_damage    = accept && (in_data.operation == OP_DAMAGE);
    assign is_frame_end = accept && (in_data.operation == OP_FRAME_END);

    // Exclusive edges of the reported rectangle.
    assign dmg_right  = {1'b0, in_data.dmg_x} + {1'b0, in_data.dmg_w};
    assign dmg_bottom = {1'b0, in_data.dmg_y} + {1'b0, in_data.dmg_h};

    // Region selection for a frame end with matching capture size.
    assign use_damage = damage_seen_reg && !first_frame_reg;
    assign size_match = (in_data.capture_width == cfg.panel_width)
                     && (in_data.capture_height == cfg.panel_height);
    assign sel_left   = use_damage ? acc_left_reg : '0;
    assign sel_top    = use_damage ? acc_top_reg : '0;
    assign sel_right  = use_damage ? acc_right_reg : {1'b0, cfg.panel_width};
    assign sel_bottom = use_damage ? acc_bottom_reg : {1'b0, cfg.panel_height};
    assign span_w     = clamp_span(sel_left, sel_right, cfg.panel_width);
    assign span_h     = clamp_span(sel_top, sel_bottom, cfg.panel_height);

    // Queue entry: the clamped region, or the full panel on a size mismatch.
    always_comb
    begin
        q_push = is_frame_end && in_data.capture_ok
              && (!size_match || (span_w != '0 && span_h != '0));
        if (size_match)
        begin
            q_data.top      = sel_top;
            q_data.left     = sel_left;
            q_data.width    = span_w;
            q_data.height   = span_h;
            q_data.rescaled = 1'b0;
        end
        else
        begin
            q_data.top      = '0;
            q_data.left     = '0;
            q_data.width    = cfg.panel_width;
            q_data.height   = cfg.panel_height;
            q_data.rescaled = 1'b1;
        end
    end

    // Damage merge and frame flags.
    always_comb
    begin
        acc_left_next    = acc_left_reg;
        acc_top_next     = acc_top_reg;
        acc_right_next   = acc_right_reg;
        acc_bottom_next  = acc_bottom_reg;
        damage_seen_next = damage_seen_reg;
        first_frame_next = first_frame_reg;
        if (is_damage)
        begin
            damage_seen_next = 1'b1;
            if (!damage_seen_reg)
            begin
                acc_left_next   = in_data.dmg_x;
                acc_top_next    = in_data.dmg_y;
                acc_right_next  = dmg_right;
                acc_bottom_next = dmg_bottom;
            end
            else
            begin
                if (in_data.dmg_x < acc_left_reg)
                begin
                    acc_left_next = in_data.dmg_x;
                end
                if (in_data.dmg_y < acc_top_reg)
                begin
                    acc_top_next = in_data.dmg_y;
                end
                if (dmg_right > acc_right_reg)
                begin
                    acc_right_next = dmg_right;
                end
                if (dmg_bottom > acc_bottom_reg)
                begin
                    acc_bottom_next = dmg_bottom;
                end
            end
        end
        if (is_frame_end)
        begin
            damage_seen_next = 1'b0;
            if (in_data.capture_ok)
            begin
                first_frame_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_left_reg    <= '0;
            acc_top_reg     <= '0;
            acc_right_reg   <= '0;
            acc_bottom_reg  <= '0;
            damage_seen_reg <= 1'b0;
            first_frame_reg <= 1'b1;
        end
        else
        begin
            acc_left_reg    <= acc_left_next;
            acc_top_reg     <= acc_top_next;
            acc_right_reg   <= acc_right_next;
            acc_bottom_reg  <= acc_bottom_next;
            damage_seen_reg <= damage_seen_next;
            first_frame_reg <= first_frame_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/drus_queue.sv
// Short queue of chosen regions between the front end and the back end.
// Depends on drus_pkg.
`default_nettype none

module drus_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire drus_pkg::region_t push_data,
    input  wire logic             pop,
    output logic                  full,
    output logic                  valid,
    output drus_pkg::region_t     head
);
    import drus_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    region_t               slot_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/drus_back.sv
// Back end: computes the region area, picks the waveform and holds the
// result in an output register. Depends on drus_pkg.
`default_nettype none

module drus_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire drus_pkg::cfg_t    cfg,
    input  wire logic             q_valid,
    input  wire drus_pkg::region_t q_head,
    output logic                  q_pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output drus_pkg::out_item_t   out_data
);
    import drus_pkg::*;

    logic [AREA_BITS-1:0] panel_area_reg;
    logic                 s1_valid_reg;
    region_t              s1_region_reg;
    logic [AREA_BITS-1:0] s1_area_reg;
    logic                 out_valid_reg;
    out_item_t            out_data_reg;

    logic                 s2_load;
    logic                 s1_load;
    logic [AREA_BITS-1:0] small_limit;
    logic                 is_small;

    // Stage enables: each stage moves when the one after it has room.
    assign s2_load = !out_valid_reg || out_ready;
    assign s1_load = !s1_valid_reg || s2_load;
    assign q_pop   = q_valid && s1_load;

    // The user must change configuration only while idle; the block does not enforce it.
    // So the panel area is recomputed freely and is settled before any region reaches the compare.
    always_ff @(posedge clk)
    begin
        panel_area_reg <= AREA_BITS'(cfg.panel_width) * AREA_BITS'(cfg.panel_height);
    end

    assign small_limit = {{SMALL_SHIFT{1'b0}}, panel_area_reg[AREA_BITS-1:SMALL_SHIFT]};
    assign is_small    = (s1_area_reg < small_limit);

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= q_valid;
            end
            if (s2_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Area multiply, then waveform selection into the output register.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_region_reg <= q_head;
            s1_area_reg   <= AREA_BITS'(q_head.width) * AREA_BITS'(q_head.height);
        end
        if (s2_load && s1_valid_reg)
        begin
            out_data_reg.upd_top     <= s1_region_reg.top;
            out_data_reg.upd_left    <= s1_region_reg.left;
            out_data_reg.upd_width   <= s1_region_reg.width;
            out_data_reg.upd_height  <= s1_region_reg.height;
            out_data_reg.waveform_id <= is_small ? cfg.fast_waveform : cfg.normal_waveform;
            out_data_reg.rescaled    <= s1_region_reg.rescaled;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

FILE: src/damage_rect_update_selector.sv
// Top level of the damage rectangle update selector: configuration registers,
// front end, region queue and back end. Depends on drus_pkg, drus_front,
// drus_queue and drus_back.
//
//   Port group   Direction  Handshake            Payload
//   in_*         input      in_valid / in_ready  drus_pkg::in_item_t
//   out_*        output     out_valid/out_ready  drus_pkg::out_item_t
//   cfg_*        input      cfg_write            cfg_index, cfg_data
//
// One request is accepted per cycle while the region queue has room.
// A frame end that produces an update is written into the queue when it is accepted,
// then moves into the area multiplier stage and from there into the output register,
// which raises out_valid. Damage reports and failed frames produce no output.
// A stalled output fills the pipeline and then the queue before in_ready drops.
// Reset is asynchronous and active low; no clearing pass is needed.
`default_nettype none

module damage_rect_update_selector #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire drus_pkg::in_item_t                      in_data,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output drus_pkg::out_item_t                          out_data,
    input  wire logic                                   cfg_write,
    input  wire logic [drus_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [drus_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
    import drus_pkg::*;

    cfg_t    cfg_reg;
    logic    q_push;
    region_t q_push_data;
    logic    q_pop;
    logic    q_full;
    logic    q_valid;
    region_t q_head;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.panel_width     <= PANEL_WIDTH_RESET;
            cfg_reg.panel_height    <= PANEL_HEIGHT_RESET;
            cfg_reg.normal_waveform <= NORMAL_WAVEFORM_RESET;
            cfg_reg.fast_waveform   <= FAST_WAVEFORM_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PANEL_WIDTH:     cfg_reg.panel_width     <= cfg_data;
                REG_PANEL_HEIGHT:    cfg_reg.panel_height    <= cfg_data;
                REG_NORMAL_WAVEFORM: cfg_reg.normal_waveform <= cfg_data[WAVE_BITS-1:0];
                REG_FAST_WAVEFORM:   cfg_reg.fast_waveform   <= cfg_data[WAVE_BITS-1:0];
            endcase
        end
    end

    drus_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_push_data)
    );

    drus_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .full      (q_full),
        .valid     (q_valid),
        .head      (q_head)
    );

    drus_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef ASSERT_OFF
    // The front end never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("region pushed into a full queue");

    // A normal update is never empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.rescaled)
            |-> (out_data.upd_width != '0 && out_data.upd_height != '0))
        else $error("empty region emitted");

    // The waveform is always one of the two configured ones.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.waveform_id == cfg_reg.fast_waveform
                    || out_data.waveform_id == cfg_reg.normal_waveform))
        else $error("waveform id not from configuration");
`endif

endmodule

`default_nettype wire
